### hdl/ray_triangle_nearest_hit_assert.svh
// Assertion macros for the ray/triangle hit block and its port checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RAY_TRIANGLE_NEAREST_HIT_ASSERT_SVH
`define RAY_TRIANGLE_NEAREST_HIT_ASSERT_SVH

// same-cycle implication, off during reset
`define RTN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RTN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rtn_pkg.sv
// Shared types, widths and codes for the ray/triangle nearest-hit block.
// No dependencies.
package rtn_pkg;

  // coordinate width is fixed by the payload structs
  localparam int CW            = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EW            = CW + 1;          // edge / difference
  localparam int PW            = 2 * EW + 1;      // cross product
  localparam int DW            = EW + PW + 2;     // dot product / determinant
  localparam int DIV_LAT       = CW + 2;          // setup + one stage per bit + saturate
  localparam int QDEPTH        = 4;
  localparam int DEPS_W        = 32;
  localparam int BEPS_W        = 16;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 32;

  localparam logic signed [CW-1:0] DIR_X_RESET = CW'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 4'd0,
    CFG_ORIGIN_Y = 4'd1,
    CFG_ORIGIN_Z = 4'd2,
    CFG_DIR_X    = 4'd3,
    CFG_DIR_Y    = 4'd4,
    CFG_DIR_Z    = 4'd5,
    CFG_DET_EPS  = 4'd6,
    CFG_BARY_EPS = 4'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_PARALLEL = 3'd1,
    ST_FAR      = 3'd2,
    ST_U_OUT    = 3'd3,
    ST_V_OUT    = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] distance_limit;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    status_t              status;
    logic signed [CW-1:0] hit_distance;
    logic signed [CW-1:0] bary_u;
    logic signed [CW-1:0] bary_v;
  } out_item_t;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic [DEPS_W-1:0]    det_epsilon;
    logic [BEPS_W-1:0]    bary_epsilon;
  } cfg_t;

  // classified triangle handed from front to back
  typedef struct packed {
    logic [DW-1:0]        det_mag;
    logic [DW-1:0]        dist_mag;
    logic [DW-1:0]        u_mag;
    logic [DW-1:0]        v_mag;
    logic                 dist_neg;
    logic                 u_neg;
    logic                 v_neg;
    logic                 parallel;
    logic signed [CW-1:0] limit;
  } q_entry_t;

  // magnitude of a signed dot product
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] x);
    return x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

endpackage

### hdl/rtn_mul.sv
// Two-stage signed multiplier, second operand split into two partial products.
// Depends on nothing.
module rtn_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic                    clk,
  input  logic                    en_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);
  localparam int LB = WB / 2;
  localparam int HB = WB - LB;

  logic signed [WA+LB:0]    plo_r;
  logic signed [WA+HB-1:0]  phi_r;
  logic signed [WA+WB-1:0]  p_r;

  // partial products, then shifted sum
  always_ff @(posedge clk) begin
    if (en_i) begin
      plo_r <= a_i * $signed({1'b0, b_i[LB-1:0]});
      phi_r <= a_i * $signed(b_i[WB-1:LB]);
      p_r   <= ((WA+WB)'(phi_r) <<< LB) + (WA+WB)'(plo_r);
    end
  end

  assign p_o = p_r;
endmodule

### hdl/rtn_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit a stage,
// signed and saturated to CW bits. Depends on rtn_pkg.
module rtn_div #(
  parameter int FRAC_BITS = rtn_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en_i,
  input  logic [rtn_pkg::DW-1:0]       num_i,
  input  logic [rtn_pkg::DW-1:0]       den_i,
  input  logic                         neg_i,
  output logic signed [rtn_pkg::CW-1:0] quo_o
);
  localparam int CW = rtn_pkg::CW;
  localparam int DW = rtn_pkg::DW;
  localparam int SH = CW - FRAC_BITS;
  localparam logic [CW-1:0] LIM = {1'b1, {(CW-1){1'b0}}};

  logic [DW-1:0] rem_r  [CW+1];
  logic [DW-1:0] den_r  [CW+1];
  logic [CW-1:0] feed_r [CW+1];
  logic [CW-1:0] quo_r  [CW+1];
  logic          big_r  [CW+1];
  logic          neg_r  [CW+1];
  logic [CW-1:0] sat_nxt;
  logic [CW-1:0] res_r;

  // setup: overflow check, top part of the dividend as first remainder
  always_ff @(posedge clk) begin
    if (en_i) begin
      big_r[0]  <= (DW+SH)'(num_i) >= {den_i, SH'(0)};
      rem_r[0]  <= num_i >> SH;
      feed_r[0] <= {num_i[SH-1:0], FRAC_BITS'(0)};
      quo_r[0]  <= '0;
      den_r[0]  <= den_i;
      neg_r[0]  <= neg_i;
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= CW; s++) begin : g_bit
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {rem_r[s-1], feed_r[s-1][CW-1]};
    assign diff  = trial - {1'b0, den_r[s-1]};
    assign ge    = trial >= {1'b0, den_r[s-1]};
    always_ff @(posedge clk) begin
      if (en_i) begin
        rem_r[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        feed_r[s] <= {feed_r[s-1][CW-2:0], 1'b0};
        quo_r[s]  <= {quo_r[s-1][CW-2:0], ge};
        den_r[s]  <= den_r[s-1];
        big_r[s]  <= big_r[s-1];
        neg_r[s]  <= neg_r[s-1];
      end
    end
  end

  // apply sign and clamp
  always_comb begin
    if (neg_r[CW]) begin
      sat_nxt = (big_r[CW] || quo_r[CW] > LIM) ? LIM : CW'(~quo_r[CW] + 1'b1);
    end else begin
      sat_nxt = (big_r[CW] || quo_r[CW][CW-1]) ? ~LIM : quo_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      res_r <= sat_nxt;
    end
  end

  assign quo_o = $signed(res_r);
endmodule

### hdl/rtn_queue.sv
// Short FIFO between front and back, flop storage.
// Depends on rtn_pkg.
module rtn_queue #(
  parameter int DEPTH = rtn_pkg::QDEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  rtn_pkg::q_entry_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output rtn_pkg::q_entry_t data_o,
  output logic              empty_o
);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  rtn_pkg::q_entry_t mem_r [DEPTH];
  logic [AW-1:0]     wr_r, rd_r;
  logic [CNTW-1:0]   cnt_r;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop_i) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= data_i;
    end
  end

  assign data_o  = mem_r[rd_r];
  assign full_o  = (cnt_r == CNTW'(DEPTH));
  assign empty_o = (cnt_r == '0);
endmodule

### hdl/rtn_front.sv
// Front: edges, cross products, determinant and numerators; flags parallel rays.
// Depends on rtn_pkg and rtn_mul.
module rtn_front (
  input  logic              clk,
  input  logic              rst_n,
  input  rtn_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  input  rtn_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  output logic              q_push_o,
  output rtn_pkg::q_entry_t q_data_o,
  input  logic              q_full_i
);
  localparam int CW   = rtn_pkg::CW;
  localparam int EW   = rtn_pkg::EW;
  localparam int PW   = rtn_pkg::PW;
  localparam int DW   = rtn_pkg::DW;
  localparam int NSTG = 8;

  logic                    fen;
  logic [NSTG-1:0]         vld_r;
  logic signed [CW-1:0]    v0 [3], v1 [3], v2 [3], org [3], dir [3];
  logic signed [EW-1:0]    e1_r [4][3], e2_r [4][3], tv_r [4][3], d_r [4][3];
  logic signed [CW-1:0]    lim_r [NSTG-1];
  logic signed [2*EW-1:0]  cpa [3], cpb [3], cqa [3], cqb [3];
  logic signed [PW-1:0]    pv_r [3], qv_r [3];
  logic signed [EW+PW-1:0] tdet [3], tdist [3], tu [3], tvv [3];
  logic signed [DW-1:0]    det_r, ndist_r, nu_r, nv_r;
  rtn_pkg::q_entry_t       q_r;

  assign v0  = '{in_data_i.v0_x, in_data_i.v0_y, in_data_i.v0_z};
  assign v1  = '{in_data_i.v1_x, in_data_i.v1_y, in_data_i.v1_z};
  assign v2  = '{in_data_i.v2_x, in_data_i.v2_y, in_data_i.v2_z};
  assign org = '{cfg_i.origin_x, cfg_i.origin_y, cfg_i.origin_z};
  assign dir = '{cfg_i.dir_x, cfg_i.dir_y, cfg_i.dir_z};

  // whole front moves unless the last stage holds an item the queue cannot take
  assign fen        = !(vld_r[NSTG-1] && q_full_i);
  assign in_stall_o = !fen;
  assign q_push_o   = vld_r[NSTG-1] && fen;
  assign q_data_o   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (fen) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid_i};
    end
  end

  // cross products: pv = dir x e2, qv = tv x e1
  for (genvar a = 0; a < 3; a++) begin : g_cross
    localparam int J = (a + 1) % 3;
    localparam int K = (a + 2) % 3;
    rtn_mul #(.WA(EW), .WB(EW)) u_pa (.clk(clk), .en_i(fen), .a_i(d_r[0][J]),
      .b_i(e2_r[0][K]), .p_o(cpa[a]));
    rtn_mul #(.WA(EW), .WB(EW)) u_pb (.clk(clk), .en_i(fen), .a_i(d_r[0][K]),
      .b_i(e2_r[0][J]), .p_o(cpb[a]));
    rtn_mul #(.WA(EW), .WB(EW)) u_qa (.clk(clk), .en_i(fen), .a_i(tv_r[0][J]),
      .b_i(e1_r[0][K]), .p_o(cqa[a]));
    rtn_mul #(.WA(EW), .WB(EW)) u_qb (.clk(clk), .en_i(fen), .a_i(tv_r[0][K]),
      .b_i(e1_r[0][J]), .p_o(cqb[a]));
  end

  // dot product terms
  for (genvar a = 0; a < 3; a++) begin : g_dot
    rtn_mul #(.WA(EW), .WB(PW)) u_det (.clk(clk), .en_i(fen), .a_i(e1_r[3][a]),
      .b_i(pv_r[a]), .p_o(tdet[a]));
    rtn_mul #(.WA(EW), .WB(PW)) u_dist (.clk(clk), .en_i(fen), .a_i(e2_r[3][a]),
      .b_i(qv_r[a]), .p_o(tdist[a]));
    rtn_mul #(.WA(EW), .WB(PW)) u_u (.clk(clk), .en_i(fen), .a_i(tv_r[3][a]),
      .b_i(pv_r[a]), .p_o(tu[a]));
    rtn_mul #(.WA(EW), .WB(PW)) u_v (.clk(clk), .en_i(fen), .a_i(d_r[3][a]),
      .b_i(qv_r[a]), .p_o(tvv[a]));
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (fen) begin
      for (int a = 0; a < 3; a++) begin
        e1_r[0][a] <= EW'(v1[a]) - EW'(v0[a]);
        e2_r[0][a] <= EW'(v2[a]) - EW'(v0[a]);
        tv_r[0][a] <= EW'(org[a]) - EW'(v0[a]);
        d_r[0][a]  <= EW'(dir[a]);
        pv_r[a]    <= PW'(cpa[a]) - PW'(cpb[a]);
        qv_r[a]    <= PW'(cqa[a]) - PW'(cqb[a]);
      end
      for (int s = 1; s < 4; s++) begin
        e1_r[s] <= e1_r[s-1];
        e2_r[s] <= e2_r[s-1];
        tv_r[s] <= tv_r[s-1];
        d_r[s]  <= d_r[s-1];
      end
      lim_r[0] <= in_data_i.distance_limit;
      for (int s = 1; s < NSTG - 1; s++) begin
        lim_r[s] <= lim_r[s-1];
      end
      det_r   <= DW'(tdet[0]) + DW'(tdet[1]) + DW'(tdet[2]);
      ndist_r <= DW'(tdist[0]) + DW'(tdist[1]) + DW'(tdist[2]);
      nu_r    <= DW'(tu[0]) + DW'(tu[1]) + DW'(tu[2]);
      nv_r    <= DW'(tvv[0]) + DW'(tvv[1]) + DW'(tvv[2]);
      // classify: magnitudes, quotient signs, parallel check
      q_r.det_mag  <= rtn_pkg::mag(det_r);
      q_r.dist_mag <= rtn_pkg::mag(ndist_r);
      q_r.u_mag    <= rtn_pkg::mag(nu_r);
      q_r.v_mag    <= rtn_pkg::mag(nv_r);
      q_r.dist_neg <= ndist_r[DW-1] ^ det_r[DW-1];
      q_r.u_neg    <= nu_r[DW-1] ^ det_r[DW-1];
      q_r.v_neg    <= nv_r[DW-1] ^ det_r[DW-1];
      q_r.parallel <= (det_r == '0) ||
                      (rtn_pkg::mag(det_r) < DW'(cfg_i.det_epsilon));
      q_r.limit    <= lim_r[NSTG-2];
    end
  end
endmodule

### hdl/rtn_back.sv
// Back: three dividers for distance, u and v, then range tests and result register.
// Depends on rtn_pkg and rtn_div.
module rtn_back #(
  parameter int FRAC_BITS = rtn_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rtn_pkg::cfg_t      cfg_i,
  input  rtn_pkg::q_entry_t  q_data_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rtn_pkg::out_item_t out_data_o
);
  localparam int CW   = rtn_pkg::CW;
  localparam int LAT  = rtn_pkg::DIV_LAT;
  localparam int CMPW = CW + 2;

  logic                 ben;
  logic                 ent_vld_r;
  rtn_pkg::q_entry_t    ent_r;
  logic [LAT-1:0]       vld_d_r;
  logic [LAT-1:0]       par_d_r;
  logic signed [CW-1:0] lim_d_r [LAT];
  logic signed [CW-1:0] dist_q, u_q, v_q;
  logic signed [CMPW-1:0] eps_s, one_s, lo_s, hi_s, u_s, v_s, uv_s;
  rtn_pkg::status_t     st_nxt;
  rtn_pkg::out_item_t   out_nxt;
  logic                 out_vld_r;
  rtn_pkg::out_item_t   out_r;

  // back moves unless a finished result is held
  assign ben     = !(out_vld_r && out_stall_i);
  assign q_pop_o = ben && !q_empty_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      vld_d_r   <= '0;
      out_vld_r <= 1'b0;
    end else if (ben) begin
      ent_vld_r <= !q_empty_i;
      vld_d_r   <= {vld_d_r[LAT-2:0], ent_vld_r};
      out_vld_r <= vld_d_r[LAT-1];
    end
  end

  rtn_div #(.FRAC_BITS(FRAC_BITS)) u_div_dist (.clk(clk), .en_i(ben),
    .num_i(ent_r.dist_mag), .den_i(ent_r.det_mag), .neg_i(ent_r.dist_neg), .quo_o(dist_q));
  rtn_div #(.FRAC_BITS(FRAC_BITS)) u_div_u (.clk(clk), .en_i(ben),
    .num_i(ent_r.u_mag), .den_i(ent_r.det_mag), .neg_i(ent_r.u_neg), .quo_o(u_q));
  rtn_div #(.FRAC_BITS(FRAC_BITS)) u_div_v (.clk(clk), .en_i(ben),
    .num_i(ent_r.v_mag), .den_i(ent_r.det_mag), .neg_i(ent_r.v_neg), .quo_o(v_q));

  // range tests, first failure wins
  always_comb begin
    eps_s = $signed(CMPW'(cfg_i.bary_epsilon));
    one_s = CMPW'(1) <<< FRAC_BITS;
    lo_s  = -eps_s;
    hi_s  = one_s + eps_s;
    u_s   = CMPW'(u_q);
    v_s   = CMPW'(v_q);
    uv_s  = u_s + v_s;
    priority if (par_d_r[LAT-1]) begin
      st_nxt = rtn_pkg::ST_PARALLEL;
    end else if (dist_q >= lim_d_r[LAT-1]) begin
      st_nxt = rtn_pkg::ST_FAR;
    end else if (u_s < lo_s || u_s > hi_s) begin
      st_nxt = rtn_pkg::ST_U_OUT;
    end else if (v_s < lo_s || uv_s > hi_s) begin
      st_nxt = rtn_pkg::ST_V_OUT;
    end else begin
      st_nxt = rtn_pkg::ST_HIT;
    end
    out_nxt.hit          = (st_nxt == rtn_pkg::ST_HIT);
    out_nxt.status       = st_nxt;
    out_nxt.hit_distance = out_nxt.hit ? dist_q : '0;
    out_nxt.bary_u       = out_nxt.hit ? u_q : '0;
    out_nxt.bary_v       = out_nxt.hit ? v_q : '0;
  end

  // payload: entry register, side data delay line, result register
  always_ff @(posedge clk) begin
    if (ben) begin
      ent_r      <= q_data_i;
      par_d_r    <= {par_d_r[LAT-2:0], ent_r.parallel};
      lim_d_r[0] <= ent_r.limit;
      for (int s = 1; s < LAT; s++) begin
        lim_d_r[s] <= lim_d_r[s-1];
      end
      out_r <= out_nxt;
    end
  end

  assign out_valid_o = out_vld_r;
  assign out_data_o  = out_r;
endmodule

### hdl/ray_triangle_nearest_hit.sv
// Top level of the ray/triangle nearest-hit test: config registers, front, queue, back.
// Depends on rtn_pkg, rtn_front, rtn_queue, rtn_back.
//
//   port group | direction | handshake           | payload
//   in_*       | input     | in_valid / in_stall | rtn_pkg::in_item_t
//   out_*      | output    | out_valid/out_stall | rtn_pkg::out_item_t
//   cfg_*      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Sustained rate: one triangle per cycle while out_stall stays low. Items pass
// through the front, the queue and the back; the depth of the back is set by the
// dividers, which resolve one quotient bit per pipeline stage.
// Reset is synchronous, active low; config registers return to their defaults.
// A held result freezes the back; the 4-entry queue keeps the front running until
// it fills, then in_stall rises. cfg_ready is always high.
module ray_triangle_nearest_hit #(
  parameter int FRAC_BITS   = rtn_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = rtn_pkg::QDEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rtn_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rtn_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtn_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int CW = rtn_pkg::CW;

  rtn_pkg::cfg_t     cfg_r;
  logic              q_push, q_full, q_pop, q_empty;
  rtn_pkg::q_entry_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.origin_z     <= '0;
      cfg_r.dir_x        <= rtn_pkg::DIR_X_RESET;
      cfg_r.dir_y        <= '0;
      cfg_r.dir_z        <= '0;
      cfg_r.det_epsilon  <= rtn_pkg::DEPS_W'(1);
      cfg_r.bary_epsilon <= rtn_pkg::BEPS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtn_pkg::CFG_ORIGIN_X: cfg_r.origin_x     <= $signed(cfg_data[CW-1:0]);
        rtn_pkg::CFG_ORIGIN_Y: cfg_r.origin_y     <= $signed(cfg_data[CW-1:0]);
        rtn_pkg::CFG_ORIGIN_Z: cfg_r.origin_z     <= $signed(cfg_data[CW-1:0]);
        rtn_pkg::CFG_DIR_X:    cfg_r.dir_x        <= $signed(cfg_data[CW-1:0]);
        rtn_pkg::CFG_DIR_Y:    cfg_r.dir_y        <= $signed(cfg_data[CW-1:0]);
        rtn_pkg::CFG_DIR_Z:    cfg_r.dir_z        <= $signed(cfg_data[CW-1:0]);
        rtn_pkg::CFG_DET_EPS:  cfg_r.det_epsilon  <= cfg_data[rtn_pkg::DEPS_W-1:0];
        rtn_pkg::CFG_BARY_EPS: cfg_r.bary_epsilon <= cfg_data[rtn_pkg::BEPS_W-1:0];
        default:               cfg_r <= cfg_r;
      endcase
    end
  end

  rtn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_r),
    .in_valid_i (in_valid),
    .in_data_i  (in_data),
    .in_stall_o (in_stall),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .q_full_i   (q_full)
  );

  rtn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  rtn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .q_data_i    (q_rdata),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );
endmodule

### hdl/rtn_checker.sv
// Port-level checks for the ray/triangle nearest-hit block, bound to the top level.
// Depends on rtn_pkg and ray_triangle_nearest_hit_assert.svh.
`include "ray_triangle_nearest_hit_assert.svh"

module rtn_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input rtn_pkg::in_item_t              in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input rtn_pkg::out_item_t             out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [rtn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [rtn_pkg::CFG_DATA_W-1:0] cfg_data
);
  logic       in_acc, out_acc;
  logic [7:0] pend_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {7'd0, in_acc} - {7'd0, out_acc};
    end
  end

  `RTN_ASSERT_IMP(a_no_orphan, out_acc, (pend_r != 8'd0), "result without a pending request")
  `RTN_ASSERT_IMP(a_hit_status, out_valid, (out_data.hit == (out_data.status == rtn_pkg::ST_HIT)), "hit flag disagrees with status")
  `RTN_ASSERT_IMP(a_miss_zero, out_valid && !out_data.hit, (out_data.hit_distance == 0 && out_data.bary_u == 0 && out_data.bary_v == 0), "miss carries nonzero payload")
  `RTN_ASSERT_NXT(a_out_hold, out_valid && out_stall, (out_valid && $stable(out_data)), "stalled result changed")
endmodule

bind ray_triangle_nearest_hit rtn_checker u_rtn_checker (.*);

### tb/tb_ray_triangle_nearest_hit.sv
// Self-checking testbench for ray_triangle_nearest_hit: directed, then random triangles
// under several ray settings, each checked against typed-in or wide-integer model values.
// Depends on rtn_pkg and the ray_triangle_nearest_hit RTL.
module tb_ray_triangle_nearest_hit;
  timeunit 1ns;
  timeprecision 1ps;
  import rtn_pkg::*;

  localparam int WW           = 160;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd12;
  localparam logic signed [31:0] ONE = 32'sd65536;

  typedef logic signed [WW-1:0] wide_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  in_item_t in_data;
  out_item_t out_data;

  ray_triangle_nearest_hit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // ray and tolerance registers as the block should hold them
  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_dir [3];
  logic [31:0] det_eps;
  logic [15:0] bary_eps;

  out_item_t hit_q[$];
  logic      pinned;       // current request carries a typed-in expectation
  out_item_t pinned_hit;
  logic      calm;         // no idling on either side
  int        hold_cycles;  // long receiver hold-off, counted down by its own process
  int        cycles;
  int        errors;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic wide_t sx(logic [31:0] x);
    return wide_t'($signed(x));
  endfunction

  // (num * 2^16) / den, truncated toward zero, saturated to 32 bits
  function automatic logic signed [31:0] sat_quot(wide_t num, wide_t den);
    wide_t q;
    q = (num <<< 16) / den;
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic void xprod(input wide_t a[3], input wide_t b[3], output wide_t r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic wide_t dprod(wide_t a[3], wide_t b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Moller-Trumbore on exact wide integers
  function automatic out_item_t ray_tri_hit(in_item_t t);
    wide_t e1[3], e2[3], tv[3], d[3], pv[3], qv[3];
    wide_t det, det_abs;
    logic [31:0] v0[3], v1[3], v2[3];
    logic signed [63:0] hit_dist, u, v, eps, lim;
    status_t st;
    out_item_t r;
    v0 = '{t.v0_x, t.v0_y, t.v0_z};
    v1 = '{t.v1_x, t.v1_y, t.v1_z};
    v2 = '{t.v2_x, t.v2_y, t.v2_z};
    for (int i = 0; i < 3; i++) begin
      e1[i] = sx(v1[i]) - sx(v0[i]);
      e2[i] = sx(v2[i]) - sx(v0[i]);
      tv[i] = sx(ray_org[i]) - sx(v0[i]);
      d[i]  = sx(ray_dir[i]);
    end
    xprod(d, e2, pv);
    det = dprod(e1, pv);
    xprod(tv, e1, qv);
    det_abs = det < 0 ? -det : det;
    hit_dist = 0; u = 0; v = 0;
    eps = 64'(bary_eps);
    lim = 64'(t.distance_limit);
    st = ST_HIT;
    if (det == 0 || det_abs < wide_t'(det_eps)) begin
      st = ST_PARALLEL;
    end else begin
      hit_dist = 64'(sat_quot(dprod(e2, qv), det));
      u        = 64'(sat_quot(dprod(tv, pv), det));
      v        = 64'(sat_quot(dprod(d, qv), det));
      if (hit_dist >= lim) st = ST_FAR;
      else if (u < -eps || u > 64'(ONE) + eps) st = ST_U_OUT;
      else if (v < -eps || u + v > 64'(ONE) + eps) st = ST_V_OUT;
    end
    if (st != ST_HIT) begin
      hit_dist = 0; u = 0; v = 0;
    end
    r.hit = (st == ST_HIT);
    r.status = st;
    r.hit_distance = hit_dist[31:0];
    r.bary_u = u[31:0];
    r.bary_v = v[31:0];
    return r;
  endfunction

  // accepted requests queue their expectation; accepted results are checked in order
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      hit_q.push_back(pinned ? pinned_hit : ray_tri_hit(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        out_item_t e;
        e = hit_q.pop_front();
        if (out_data.hit !== e.hit || out_data.status !== e.status ||
            out_data.hit_distance !== e.hit_distance || out_data.bary_u !== e.bary_u ||
            out_data.bary_v !== e.bary_v) begin
          $display("%0t: expected hit=%0b status=%s dist=%0d u=%0d v=%0d", $time,
                   e.hit, e.status.name(), e.hit_distance, e.bary_u, e.bary_v);
          $display("%0t: actual   hit=%0b status=%0d dist=%0d u=%0d v=%0d", $time,
                   out_data.hit, out_data.status, out_data.hit_distance,
                   out_data.bary_u, out_data.bary_v);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 23);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_triangle_nearest_hit: mismatch");
      $finish;
    end
  end

  task automatic send(in_item_t t, logic has_exp, out_item_t e);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    pinned <= has_exp;
    pinned_hit <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: ray_org[0] = val;
      CFG_ORIGIN_Y: ray_org[1] = val;
      CFG_ORIGIN_Z: ray_org[2] = val;
      CFG_DIR_X:    ray_dir[0] = val;
      CFG_DIR_Y:    ray_dir[1] = val;
      CFG_DIR_Z:    ray_dir[2] = val;
      CFG_DET_EPS:  det_eps = val;
      CFG_BARY_EPS: bary_eps = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_ray(logic [31:0] o[3], logic [31:0] d[3], logic [31:0] de,
                         logic [31:0] be);
    cfg_write(CFG_ORIGIN_X, o[0]);
    cfg_write(CFG_ORIGIN_Y, o[1]);
    cfg_write(CFG_ORIGIN_Z, o[2]);
    cfg_write(CFG_DIR_X, d[0]);
    cfg_write(CFG_DIR_Y, d[1]);
    cfg_write(CFG_DIR_Z, d[2]);
    cfg_write(CFG_DET_EPS, de);
    cfg_write(CFG_BARY_EPS, be);
  endtask

  // triangle near the ray at some distance, or noise, or extreme values
  function automatic in_item_t rand_triangle();
    logic [31:0] c[3];
    logic [31:0] f[10];
    int kind, span;
    in_item_t t;
    logic signed [63:0] tt;
    kind = $urandom_range(99);
    tt = $urandom_range(12);
    span = $urandom_range(3) == 0 ? 1 << 20 : 1 << 17;
    for (int i = 0; i < 3; i++)
      c[i] = 32'(64'(ray_org[i]) + 64'(ray_dir[i]) * tt);
    for (int i = 0; i < 9; i++) begin
      if (kind < 65) f[i] = c[i % 3] + $urandom_range(2 * span) - span;
      else if (kind < 85) f[i] = $urandom;
      else f[i] = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    end
    case ($urandom_range(3))
      0: f[9] = 32'h7fffffff;
      1: f[9] = $urandom_range(20) << 16;
      2: f[9] = $urandom;
      default: f[9] = $urandom_range(1) ? 32'h80000000 : 32'h0;
    endcase
    t = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]};
    return t;
  endfunction

  typedef struct {
    in_item_t  item;
    logic      has_exp;
    out_item_t exp_hit;
  } dir_row_t;

  initial begin
    out_item_t none, miss_par, miss_far;
    dir_row_t rows[$];
    logic [31:0] o[3], d[3];
    in_item_t flat_pos, flat_neg, wall, t;
    none = '0;
    miss_par = '{hit: 1'b0, status: ST_PARALLEL, hit_distance: 0, bary_u: 0, bary_v: 0};
    miss_far = '{hit: 1'b0, status: ST_FAR, hit_distance: 0, bary_u: 0, bary_v: 0};

    rst_n = 1'b0;
    in_valid = 1'b0; in_data = '0; pinned = 1'b0; pinned_hit = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    out_stall = 1'b0; calm = 1'b0; hold_cycles = 0; cycles = 0; errors = 0;
    ray_org = '{0, 0, 0};
    ray_dir = '{DIR_X_RESET, 0, 0};
    det_eps = 1;
    bary_eps = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests under the reset ray (+x from the origin)
    flat_pos = {10{32'h7fffffff}};
    flat_neg = {10{32'h80000000}};
    wall = {32'h20000, 32'hffff0000, 32'hffff0000, 32'h20000, 32'h10000, 32'hffff0000,
            32'h20000, 32'hffff0000, 32'h10000, 32'h7fffffff};
    rows.push_back('{'0, 1'b1, miss_par});
    rows.push_back('{flat_pos, 1'b1, miss_par});
    rows.push_back('{flat_neg, 1'b1, miss_par});
    t = wall; t.distance_limit = 32'hfffb0000;
    rows.push_back('{t, 1'b1, miss_far});      // hit lies beyond a negative limit
    rows.push_back('{wall, 1'b0, none});       // edge hit of a wall at x=2
    t = wall; t.distance_limit = 32'h20000;
    rows.push_back('{t, 1'b0, none});          // distance equal to the limit
    t = wall; t.distance_limit = 32'h20001;
    rows.push_back('{t, 1'b0, none});
    t = wall; t.v0_y = 32'h10000; t.v1_y = 32'h30000; t.v2_y = 32'h10000;
    rows.push_back('{t, 1'b0, none});          // u out of range
    t = wall; t.v0_z = 32'h10000; t.v1_z = 32'h10000; t.v2_z = 32'h30000;
    rows.push_back('{t, 1'b0, none});          // v out of range
    t = wall; t.v0_y = 32'h0; t.v0_z = 32'h0;
    rows.push_back('{t, 1'b0, none});          // degenerate triangle with a vertex on the ray
    t = wall; t.v0_x = 32'hfffe0000; t.v1_x = 32'hfffe0000; t.v2_x = 32'hfffe0000;
    rows.push_back('{t, 1'b0, none});          // triangle behind the origin
    t = wall; t.v1_x = 32'h7fffffff; t.v2_x = 32'h80000000;
    rows.push_back('{t, 1'b0, none});
    t = {32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
         32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff};
    rows.push_back('{t, 1'b0, none});          // saturating quotients
    t = {32'h1, 32'h7fffffff, 32'h80000000, 32'h1, 32'h80000000, 32'h7fffffff,
         32'h2, 32'h80000000, 32'h80000000, 32'h80000000};
    rows.push_back('{t, 1'b0, none});
    t = {32'h10000, 32'h0, 32'h0, 32'h10000, 32'h1, 32'h0, 32'h10000, 32'h0, 32'h1,
         32'h7fffffff};
    rows.push_back('{t, 1'b0, none});          // tiny determinant above the threshold
    foreach (rows[i]) send(rows[i].item, rows[i].has_exp, rows[i].exp_hit);
    pinned <= 1'b0;
    drain();

    // random phases, each with its own ray setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          for (int i = 0; i < 3; i++) begin
            o[i] = $urandom_range(8 << 16) - (4 << 16);
            d[i] = $urandom_range(2 << 16) - (1 << 16);
          end
          set_ray(o, d, 1, 0);
          cfg_write(CFG_UNUSED_IDX, $urandom);
        end
        1: begin
          o = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
          d = '{32'h80000000, 32'h7fffffff, 32'h80000000};
          set_ray(o, d, 0, 16'hffff);
        end
        2: begin
          for (int i = 0; i < 3; i++) begin
            o[i] = $urandom;
            d[i] = $urandom;
          end
          set_ray(o, d, 32'hffffffff, $urandom_range(16'hffff));
        end
        3: begin
          for (int i = 0; i < 3; i++) begin
            o[i] = $urandom_range(1 << 20) - (1 << 19);
            d[i] = $urandom_range(1 << 18) - (1 << 17);
          end
          set_ray(o, d, $urandom_range(1 << 16), 16'hffff);
        end
        4: begin
          o = '{0, 0, 0};
          d = '{32'h0, 32'h0, 32'h10000};
          set_ray(o, d, $urandom, $urandom_range(64));
        end
        default: begin
          o = '{0, 0, 0};
          d = '{DIR_X_RESET, 0, 0};
          set_ray(o, d, 1, 1);
        end
      endcase
      for (int n = 0; n < 215; n++) begin
        calm = (ph == 3 && n >= 40 && n < 140);
        if (ph == 2 && n == 50) hold_cycles <= 300;
        send(rand_triangle(), 1'b0, none);
      end
      calm = 1'b0;
      drain();   // sender pauses until every result is back
    end

    if (errors == 0 && hit_q.size() == 0) begin
      $display("ray_triangle_nearest_hit: match");
    end else begin
      $display("ray_triangle_nearest_hit: mismatch");
    end
    $finish;
  end

endmodule
